/* sv/kms_pkg.sv */
// Package for the keypad matrix scanner.
// It holds the scan phase type, the pin widths, the reset value of the debounce register and the result struct.
// It depends on nothing else.
`default_nettype none

package kms_pkg;

    // The pin counts are fixed by the board wiring, not by the matrix size.
    localparam int COL_PINS = 7;
    localparam int ROW_PINS = 3;
    localparam int COL_NUM_W = 3;
    localparam int DEBOUNCE_W = 16;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd100;

    typedef enum logic [4:0] {
        PH_IDLE     = 5'b00001,
        PH_WAIT_COL = 5'b00010,
        PH_SCAN     = 5'b00100,
        PH_DRIVE    = 5'b01000,
        PH_WAIT_ROW = 5'b10000
    } scan_phase_t;

    typedef struct packed {
        logic                 rows_driven_low;
        logic [COL_NUM_W-1:0] driven_column;
        logic                 key_valid;
        logic [COL_NUM_W-1:0] key_column;
        logic [ROW_PINS-1:0]  key_rows;
    } scan_result_t;

endpackage

`default_nettype wire

/* sv/keypad_matrix_scanner.sv */
// Top level of the keypad matrix scanner: line-reversal scan with debounce.
// It depends on kms_pkg for the phase type, the pin widths and the result struct.
//
//   Channel   Signals                                  Direction  Beat carries
//   input     in_valid, in_ready                       in         column_levels, row_levels
//   output    out_valid, out_ready                     out        drive pattern and key report
//   config    cfg_write_en, cfg_write_data             in         debounce_ticks
//
// Every input beat is one tick of the scan and yields exactly one output beat.
// The block takes one beat per clock cycle while its output is not stalled, and
// registers the result in the output register.
// A beat is taken whenever the output register is empty or is being drained in the
// same cycle, so a stalled output holds its beat and stalls only the input.
// Reset puts the scanner at rest (rows driven low), column zero, count zero, and
// loads the debounce register with 100 ticks.
`default_nettype none

module keypad_matrix_scanner
    import kms_pkg::*;
#(
    parameter int NUM_ROWS    = 3,
    parameter int NUM_COLUMNS = 7
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [COL_PINS-1:0]   column_levels,
    input  wire logic [ROW_PINS-1:0]   row_levels,

    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic                       rows_driven_low,
    output logic [COL_NUM_W-1:0]       driven_column,
    output logic                       key_valid,
    output logic [COL_NUM_W-1:0]       key_column,
    output logic [ROW_PINS-1:0]        key_rows,

    input  wire logic                  cfg_write_en,
    input  wire logic [DEBOUNCE_W-1:0] cfg_write_data
);

    // Matrix lines beyond the pins have no wiring, so they are never scanned.
    localparam int USED_COLS = (NUM_COLUMNS < COL_PINS) ? NUM_COLUMNS : COL_PINS;
    localparam int USED_ROWS = (NUM_ROWS < ROW_PINS) ? NUM_ROWS : ROW_PINS;
    localparam logic [COL_PINS-1:0] COL_MASK = COL_PINS'((1 << USED_COLS) - 1);
    localparam logic [ROW_PINS-1:0] ROW_MASK = ROW_PINS'((1 << USED_ROWS) - 1);
    localparam logic [COL_NUM_W:0]  LAST_COL = (COL_NUM_W + 1)'(USED_COLS);

    scan_phase_t                 phase_reg, phase_next;
    logic [COL_NUM_W-1:0]        column_reg, column_next;
    logic [DEBOUNCE_W-1:0]       count_reg, count_next;
    logic [DEBOUNCE_W-1:0]       debounce_ticks_reg;
    logic                        out_valid_reg;
    scan_result_t                result_reg, result_next;

    logic                        accept;
    logic [COL_PINS-1:0]         col_low;
    logic [ROW_PINS-1:0]         row_low;
    logic [COL_NUM_W:0]          col_inc;
    logic                        last_column;
    logic                        released;

    // The output register is the only storage between the two sides, so the input
    // is ready whenever that register is empty or is handing its beat over now.
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // Pins read low when a key closes the line; active-high masks are easier to test.
    assign col_low = ~column_levels & COL_MASK;
    assign row_low = ~row_levels & ROW_MASK;

    // Stepping to the next column ends the walk after the last wired column.
    assign col_inc     = {1'b0, column_reg} + 1'b1;
    assign last_column = (col_inc >= LAST_COL);

    always_comb
    begin
        phase_next  = phase_reg;
        column_next = column_reg;
        count_next  = count_reg;
        result_next = '0;

        unique case (phase_reg)
            PH_WAIT_COL:
            begin
                // Count down the debounce time, then see whether a column is still low.
                if (count_reg != '0) begin
                    count_next = count_reg - 1'b1;
                end else if (col_low != '0) begin
                    column_next = '0;
                    phase_next  = PH_SCAN;
                end else begin
                    phase_next = PH_IDLE;
                end
            end
            PH_SCAN:
            begin
                if ({1'b0, column_reg} >= LAST_COL) begin
                    column_next = '0;
                    phase_next  = PH_IDLE;
                end else if (col_low[column_reg]) begin
                    phase_next = PH_DRIVE;
                end else if (last_column) begin
                    column_next = '0;
                    phase_next  = PH_IDLE;
                end else begin
                    column_next = col_inc[COL_NUM_W-1:0];
                    phase_next  = PH_SCAN;
                end
            end
            PH_DRIVE:
            begin
                // The rows were sampled with this column driven low and the rows released.
                if (row_low != '0) begin
                    count_next = debounce_ticks_reg;
                    phase_next = PH_WAIT_ROW;
                end else if (last_column) begin
                    column_next = '0;
                    phase_next  = PH_IDLE;
                end else begin
                    column_next = col_inc[COL_NUM_W-1:0];
                    phase_next  = PH_SCAN;
                end
            end
            PH_WAIT_ROW:
            begin
                if (count_reg != '0) begin
                    count_next = count_reg - 1'b1;
                end else begin
                    // A row still low after the wait is a debounced press in this column.
                    if (row_low != '0) begin
                        result_next.key_valid  = 1'b1;
                        result_next.key_column = col_inc[COL_NUM_W-1:0];
                        result_next.key_rows   = row_low;
                    end
                    if (last_column) begin
                        column_next = '0;
                        phase_next  = PH_IDLE;
                    end else begin
                        column_next = col_inc[COL_NUM_W-1:0];
                        phase_next  = PH_SCAN;
                    end
                end
            end
            default:
            begin
                // At rest, and for any phase code that should never occur.
                column_next = '0;
                phase_next  = PH_IDLE;
                if (col_low != '0) begin
                    count_next = debounce_ticks_reg;
                    phase_next = PH_WAIT_COL;
                end
            end
        endcase

        // The drive pattern announced here is the one the next tick is sampled under.
        released                    = (phase_next == PH_DRIVE) || (phase_next == PH_WAIT_ROW);
        result_next.rows_driven_low = !released;
        result_next.driven_column   = released ? COL_NUM_W'({1'b0, column_next} + 1'b1) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg          <= PH_IDLE;
            column_reg         <= '0;
            count_reg          <= '0;
            debounce_ticks_reg <= DEBOUNCE_RESET;
            out_valid_reg      <= 1'b0;
        end else begin
            if (cfg_write_en) begin
                debounce_ticks_reg <= cfg_write_data;
            end
            if (accept) begin
                phase_reg     <= phase_next;
                column_reg    <= column_next;
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload needs no reset; it is only looked at while out_valid is high.
    always_ff @(posedge clk)
    begin
        if (accept) begin
            result_reg <= result_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign rows_driven_low = result_reg.rows_driven_low;
    assign driven_column   = result_reg.driven_column;
    assign key_valid       = result_reg.key_valid;
    assign key_column      = result_reg.key_column;
    assign key_rows        = result_reg.key_rows;

endmodule

`default_nettype wire

/* sv/kms_checker.sv */
// Port-level checker for the keypad matrix scanner, bound to the top level.
// It depends on kms_pkg for the pin widths.
`default_nettype none

module kms_checker
    import kms_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  out_valid,
    input wire logic                  out_ready,
    input wire logic                  rows_driven_low,
    input wire logic [COL_NUM_W-1:0]  driven_column,
    input wire logic                  key_valid,
    input wire logic [COL_NUM_W-1:0]  key_column,
    input wire logic [ROW_PINS-1:0]   key_rows
);

    // A stalled output beat keeps its whole payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(rows_driven_low)
            && $stable(driven_column) && $stable(key_valid)
            && $stable(key_column) && $stable(key_rows))
        else $error("stalled output beat changed");

    // The rest pattern drives no column, and a released pattern always names one.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (rows_driven_low == (driven_column == '0)))
        else $error("drive pattern and driven column disagree");

    // A key report always carries a column and at least one row.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && key_valid |-> (key_column != '0) && (key_rows != '0))
        else $error("key report without column or rows");

    // Without a report the key fields are zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !key_valid |-> (key_column == '0) && (key_rows == '0))
        else $error("key fields set without a report");

    // A report comes at the end of a row wait, so the next tick starts from a new column
    // or from rest, never from the same released column.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && key_valid |-> rows_driven_low || (driven_column != key_column))
        else $error("reported column still driven after its report");

endmodule

bind keypad_matrix_scanner kms_checker u_kms_checker (.*);

`default_nettype wire

/* bench/kms_scoreboard_pkg.sv */
// Scoreboard for the keypad matrix scanner bench: a beat-by-beat scan predictor
// and the queue of output beats it says are due. Depends on kms_pkg for the phase
// type and the output beat struct.
`default_nettype none

package kms_tb_pkg;

    import kms_pkg::*;

    // Matrix size of the block under test. It matches the pin counts, so every
    // column and row bit is in use and no masking of pin bits is needed.
    localparam int SCAN_COLUMNS = 7;
    localparam int SCAN_ROWS    = 3;

    class keypad_scoreboard;

        scan_phase_t           phase;
        logic [COL_NUM_W-1:0]  column_at;
        logic [DEBOUNCE_W-1:0] ticks_left;
        logic [DEBOUNCE_W-1:0] debounce_ticks;

        // Drive pattern announced by the last predicted beat; the pin model
        // in the bench samples the key matrix under this pattern.
        logic                  drive_rows_low;
        logic [COL_NUM_W-1:0]  drive_column;

        scan_result_t          results_due[$];
        int                    failures;

        function new();
            phase          = PH_IDLE;
            column_at      = '0;
            ticks_left     = '0;
            debounce_ticks = 16'd100;
            drive_rows_low = 1'b1;
            drive_column   = '0;
            failures       = 0;
        endfunction

        function void set_debounce(logic [DEBOUNCE_W-1:0] value);
            debounce_ticks = value;
        endfunction

        function int pending();
            return results_due.size();
        endfunction

        // After the last column the walk ends and the scanner goes back to rest.
        local function void step_column();
            if (int'(column_at) + 1 >= SCAN_COLUMNS)
            begin
                column_at = '0;
                phase     = PH_IDLE;
            end
            else
            begin
                column_at = column_at + 1'b1;
                phase     = PH_SCAN;
            end
        endfunction

        function scan_result_t note_sample(logic [COL_PINS-1:0] cols, logic [ROW_PINS-1:0] rows);
            scan_result_t         r;
            logic [COL_PINS-1:0]  col_low;
            logic [ROW_PINS-1:0]  row_low;
            logic                 released;
            col_low = ~cols;
            row_low = ~rows;
            r       = '0;
            case (phase)
                PH_WAIT_COL:
                begin
                    if (ticks_left != 0)
                        ticks_left = ticks_left - 1'b1;
                    else if (col_low != 0)
                    begin
                        column_at = '0;
                        phase     = PH_SCAN;
                    end
                    else
                        phase = PH_IDLE;
                end
                PH_SCAN:
                begin
                    if (int'(column_at) >= SCAN_COLUMNS)
                    begin
                        column_at = '0;
                        phase     = PH_IDLE;
                    end
                    else if (col_low[column_at])
                        phase = PH_DRIVE;
                    else
                        step_column();
                end
                PH_DRIVE:
                begin
                    if (row_low != 0)
                    begin
                        ticks_left = debounce_ticks;
                        phase      = PH_WAIT_ROW;
                    end
                    else
                        step_column();
                end
                PH_WAIT_ROW:
                begin
                    if (ticks_left != 0)
                        ticks_left = ticks_left - 1'b1;
                    else
                    begin
                        if (row_low != 0)
                        begin
                            r.key_valid  = 1'b1;
                            r.key_column = column_at + 1'b1;
                            r.key_rows   = row_low;
                        end
                        step_column();
                    end
                end
                default:
                begin
                    column_at = '0;
                    phase     = PH_IDLE;
                    if (col_low != 0)
                    begin
                        ticks_left = debounce_ticks;
                        phase      = PH_WAIT_COL;
                    end
                end
            endcase
            released          = (phase inside {PH_DRIVE, PH_WAIT_ROW});
            r.rows_driven_low = !released;
            r.driven_column   = released ? column_at + 1'b1 : '0;
            drive_rows_low    = r.rows_driven_low;
            drive_column      = r.driven_column;
            results_due.push_back(r);
            return r;
        endfunction

        function void check_result(scan_result_t got);
            scan_result_t want;
            if (results_due.size() == 0)
            begin
                $error("output beat %h arrived with no result due", got);
                failures++;
                return;
            end
            want = results_due.pop_front();
            if (got.rows_driven_low !== want.rows_driven_low)
            begin
                $error("rows_driven_low: expected %0d, actual %0d",
                       want.rows_driven_low, got.rows_driven_low);
                failures++;
            end
            if (got.driven_column !== want.driven_column)
            begin
                $error("driven_column: expected %0d, actual %0d",
                       want.driven_column, got.driven_column);
                failures++;
            end
            if (got.key_valid !== want.key_valid)
            begin
                $error("key_valid: expected %0d, actual %0d", want.key_valid, got.key_valid);
                failures++;
            end
            if (got.key_column !== want.key_column)
            begin
                $error("key_column: expected %0d, actual %0d", want.key_column, got.key_column);
                failures++;
            end
            if (got.key_rows !== want.key_rows)
            begin
                $error("key_rows: expected %0d, actual %0d", want.key_rows, got.key_rows);
                failures++;
            end
        endfunction

    endclass

endpackage

`default_nettype wire

/* bench/tb_top.sv */
// Top-level bench for the keypad matrix scanner: drives pin samples shaped by a
// simulated key matrix, checks every output beat against the scoreboard.
// Depends on kms_pkg and on kms_tb_pkg for the scoreboard class.
`default_nettype none

module tb_top;

    import kms_pkg::*;
    import kms_tb_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [COL_PINS-1:0]   column_levels;
    logic [ROW_PINS-1:0]   row_levels;
    logic                  out_valid;
    logic                  out_ready;
    logic                  rows_driven_low;
    logic [COL_NUM_W-1:0]  driven_column;
    logic                  key_valid;
    logic [COL_NUM_W-1:0]  key_column;
    logic [ROW_PINS-1:0]   key_rows;
    logic                  cfg_write_en;
    logic [DEBOUNCE_W-1:0] cfg_write_data;

    // Percent of cycles in which the sender holds back a beat, and in which the
    // receiver drops out_ready. Changed between phases of the run.
    int send_idle_pct;
    int recv_idle_pct;

    keypad_scoreboard scoreboard;
    scan_result_t     last_prediction;

    // The simulated keypad: key_map[c][r] is 1 while the key at column c+1,
    // row r+1 is held down.
    logic [ROW_PINS-1:0] key_map [COL_PINS];

    keypad_matrix_scanner i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .column_levels   (column_levels),
        .row_levels      (row_levels),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .rows_driven_low (rows_driven_low),
        .driven_column   (driven_column),
        .key_valid       (key_valid),
        .key_column      (key_column),
        .key_rows        (key_rows),
        .cfg_write_en    (cfg_write_en),
        .cfg_write_data  (cfg_write_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Receiver back-pressure. The value is changed on the falling edge only, so
    // the rising edge always sees a settled out_ready.
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    // Every output beat taken at a rising edge goes to the scoreboard. The block
    // registers its result, so the expectation for a beat is always queued at an
    // earlier edge than the one where its result is taken.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            scoreboard.check_result(scan_result_t'({rows_driven_low, driven_column,
                                                    key_valid, key_column, key_rows}));
    end

    // Sends one input beat. Optional idle cycles come first; once valid is raised
    // it stays high with the same pin levels until the block takes the beat.
    task automatic send_beat(input logic [COL_PINS-1:0] cols, input logic [ROW_PINS-1:0] rows);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid      <= 1'b1;
        column_levels <= cols;
        row_levels    <= rows;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        last_prediction = scoreboard.note_sample(cols, rows);
    endtask

    // Pin levels the keypad would show under the drive pattern the scanner has
    // announced. With the rows driven low, a column reads low when any key in it
    // is held. With one column driven low, the rows of its held keys read low.
    // A noisy sample flips random bits, standing in for contact bounce.
    function automatic void pins_now(input logic noisy, output logic [COL_PINS-1:0] cols,
                                     output logic [ROW_PINS-1:0] rows);
        int c;
        if (scoreboard.drive_rows_low)
        begin
            rows = '0;
            for (c = 0; c < COL_PINS; c++)
                cols[c] = (key_map[c] == '0);
        end
        else
        begin
            c       = int'(scoreboard.drive_column) - 1;
            cols    = '1;
            cols[c] = 1'b0;
            rows    = ~key_map[c];
        end
        if (noisy)
        begin
            cols ^= COL_PINS'($urandom());
            rows ^= ROW_PINS'($urandom());
        end
    endfunction

    task automatic send_keypad_beat(input logic noisy);
        logic [COL_PINS-1:0] cols;
        logic [ROW_PINS-1:0] rows;
        pins_now(noisy, cols, rows);
        send_beat(cols, rows);
    endtask

    // Keys are pressed and released now and then: a single key toggles, the
    // whole pad is let go, or a fresh chord of keys goes down. This keeps some
    // rechecks failing and many scans reaching a report.
    function automatic void churn_keys();
        int roll;
        roll = $urandom_range(99);
        if (roll < 3)
            key_map[$urandom_range(COL_PINS-1)][$urandom_range(ROW_PINS-1)] ^= 1'b1;
        else if (roll < 6)
        begin
            foreach (key_map[i])
                key_map[i] = '0;
            if (roll != 3)
            begin
                key_map[$urandom_range(COL_PINS-1)] = ROW_PINS'($urandom());
                if ($urandom_range(1) == 1)
                    key_map[$urandom_range(COL_PINS-1)] |= ROW_PINS'($urandom());
            end
        end
    endfunction

    // Lets every outstanding result come out, then a few more cycles, so that
    // the block is quiet before the debounce register is touched.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (scoreboard.pending() != 0)
            @(posedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic write_debounce(input logic [DEBOUNCE_W-1:0] value);
        drain();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(negedge clk);
        cfg_write_en   <= 1'b0;
        scoreboard.set_debounce(value);
    endtask

    task automatic run_segment(input logic [DEBOUNCE_W-1:0] debounce, input int beats);
        write_debounce(debounce);
        repeat (beats)
        begin
            churn_keys();
            send_keypad_beat($urandom_range(99) < 8);
        end
    endtask

    initial
    begin
        int guard;
        scoreboard     = new();
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        column_levels  = '1;
        row_levels     = '1;
        cfg_write_en   = 1'b0;
        cfg_write_data = '0;
        send_idle_pct  = 27;
        recv_idle_pct  = 57;
        foreach (key_map[i])
            key_map[i] = '0;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, with no debounce delay so each scan is short. All pins
        // high leaves the scanner at rest. A single key in the first column gives
        // a one-row report, then a full column of keys in the last column gives a
        // report with every row and the highest column. All pins low ends it.
        write_debounce('0);
        send_beat('1, '1);
        key_map[0] = 3'b001;
        repeat (11) send_keypad_beat(1'b0);
        key_map[0] = '0;
        key_map[COL_PINS-1] = 3'b111;
        repeat (11) send_keypad_beat(1'b0);
        send_beat('0, '0);

        // Random part, first with a slow receiver, then with a slow sender.
        run_segment(16'd0, 200);
        run_segment(16'd100, 200);
        run_segment(16'd4, 200);

        send_idle_pct = 57;
        recv_idle_pct = 27;
        run_segment(16'd1, 200);
        run_segment(16'd7, 200);
        run_segment(16'd0, 150);

        // Full rate on both sides.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_segment(16'd2, 150);
        run_segment(16'd0, 100);

        // Long debounce: hold one key steady until a wait starts with the full
        // count, then write zero while that wait is running. The running count
        // must still run down all the way, and only the next wait uses zero.
        write_debounce(16'd200);
        foreach (key_map[i])
            key_map[i] = '0;
        key_map[3] = 3'b010;
        guard = 0;
        while (scoreboard.ticks_left < 16'd150 && guard < 40)
        begin
            send_keypad_beat(1'b0);
            guard++;
        end
        write_debounce('0);
        guard = 0;
        while (!last_prediction.key_valid && guard < 1000)
        begin
            send_keypad_beat(1'b0);
            guard++;
        end

        @(negedge clk);
        in_valid <= 1'b0;
        guard = 0;
        while (scoreboard.pending() != 0 && guard < 2000)
        begin
            @(posedge clk);
            guard++;
        end
        if (scoreboard.pending() != 0)
        begin
            $error("%0d output beats never arrived", scoreboard.pending());
            scoreboard.failures++;
        end
        repeat (4) @(posedge clk);
        if (scoreboard.failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // A run that hangs on a handshake ends here instead.
    initial
    begin
        #10000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire
